// ===== hw/rtl/sri_pkg.sv =====
// Shared types and register codes for the serial controller register front end.
package sri_pkg;

  // Transaction kinds on the input channel.
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_CARRIER = 2'd2;

  // Register pointer values that select a register.
  localparam logic [3:0] PTR_CMD   = 4'd0;
  localparam logic [3:0] PTR_IMASK = 4'd1;
  localparam logic [3:0] PTR_VEC   = 4'd2;
  localparam logic [3:0] PTR_MCTL  = 4'd9;
  localparam logic [3:0] PTR_EXT   = 4'd15;

  // Command codes in bits 5..3 of a pointer-zero control write.
  localparam logic [2:0] CMD_POINT_HIGH = 3'd1;
  localparam logic [2:0] CMD_RESET_EXT  = 3'd2;

  // Bit positions inside the control registers.
  localparam int MCTL_MIE_BIT  = 3;
  localparam int MCTL_VSHI_BIT = 4;
  localparam int EXT_DCD_BIT   = 3;

  // Status codes placed in the vector for an active channel.
  localparam logic [2:0] VEC_CODE_CH0 = 3'b001;
  localparam logic [2:0] VEC_CODE_CH1 = 3'b101;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] bus_address;
    logic [7:0] write_data;
    logic       dcd_channel;
    logic       dcd_level;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       irq_changed;
  } result_t;

endpackage

// ===== hw/rtl/sri_core.sv =====
// Register file and single-pass decode of one transaction for the front end.
module sri_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  sri_pkg::item_t  item,
  output sri_pkg::result_t result
);
  import sri_pkg::*;

  logic [3:0] ptr_r, ptr_nxt;
  logic [7:0] vec_r, vec_nxt;
  logic [7:0] mctl_r, mctl_nxt;
  logic [7:0] imask_r [2];
  logic [7:0] imask_nxt [2];
  logic [7:0] emask_r [2];
  logic [7:0] emask_nxt [2];
  logic [1:0] carrier_r, carrier_nxt;
  logic [1:0] pend_r, pend_nxt;
  logic [7:0] estat_r [2];
  logic [7:0] estat_nxt [2];
  logic       last_irq_r, last_irq_nxt;

  logic       ch;
  logic       ctrl_port;
  logic [2:0] cmd;
  logic [1:0] chan_act;
  logic [1:0] chan_act_nxt;
  logic [7:0] rd;
  logic       line;

  always_comb begin
    ch        = item.bus_address[0];
    ctrl_port = !item.bus_address[1];
    cmd       = item.write_data[5:3];

    ptr_nxt      = ptr_r;
    vec_nxt      = vec_r;
    mctl_nxt     = mctl_r;
    imask_nxt    = imask_r;
    emask_nxt    = emask_r;
    carrier_nxt  = carrier_r;
    pend_nxt     = pend_r;
    estat_nxt    = estat_r;
    rd           = 8'h00;

    for (int i = 0; i < 2; i++) begin
      chan_act[i] = imask_r[i][0] && pend_r[i];
    end

    case (item.opcode)
      OP_READ: begin
        if (ctrl_port) begin
          unique case (ptr_r)
            PTR_CMD: rd = carrier_r[ch] ? 8'h08 : 8'h00;
            PTR_EXT: rd = estat_r[ch];
            PTR_VEC: begin
              if (!ch) begin
                rd = vec_r;
                // Status modification: the lower-numbered active channel wins.
                if (chan_act != 2'b00) begin
                  if (mctl_r[MCTL_VSHI_BIT]) begin
                    rd[6:4] = chan_act[0] ? VEC_CODE_CH0 : VEC_CODE_CH1;
                  end else begin
                    rd[3:1] = chan_act[0] ? VEC_CODE_CH0 : VEC_CODE_CH1;
                  end
                end
              end
            end
            default: rd = 8'h00;
          endcase
          ptr_nxt = 4'd0;
        end
      end
      OP_WRITE: begin
        if (ctrl_port) begin
          unique case (ptr_r)
            PTR_CMD: begin
              if (cmd == CMD_RESET_EXT) begin
                pend_nxt[ch]  = 1'b0;
                estat_nxt[ch] = 8'h00;
              end
            end
            PTR_IMASK: imask_nxt[ch] = item.write_data;
            PTR_VEC:   vec_nxt       = item.write_data;
            PTR_MCTL:  mctl_nxt      = item.write_data;
            PTR_EXT:   emask_nxt[ch] = item.write_data;
            default: ;
          endcase
          if (ptr_r != PTR_CMD) begin
            ptr_nxt = 4'd0;
          end else begin
            ptr_nxt = {cmd == CMD_POINT_HIGH, item.write_data[2:0]};
          end
        end
      end
      OP_CARRIER: begin
        if (carrier_r[item.dcd_channel] != item.dcd_level) begin
          carrier_nxt[item.dcd_channel] = item.dcd_level;
          if (emask_r[item.dcd_channel][EXT_DCD_BIT]) begin
            pend_nxt[item.dcd_channel]               = 1'b1;
            estat_nxt[item.dcd_channel][EXT_DCD_BIT] = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // The interrupt line reflects the state after this transaction.
    for (int i = 0; i < 2; i++) begin
      chan_act_nxt[i] = imask_nxt[i][0] && pend_nxt[i];
    end
    line         = mctl_nxt[MCTL_MIE_BIT] && (chan_act_nxt != 2'b00);
    last_irq_nxt = line;

    result.read_data   = rd;
    result.irq_line    = line;
    result.irq_changed = line != last_irq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      vec_r      <= '0;
      mctl_r     <= '0;
      imask_r    <= '{default: '0};
      emask_r    <= '{default: '0};
      carrier_r  <= '0;
      pend_r     <= '0;
      estat_r    <= '{default: '0};
      last_irq_r <= 1'b0;
    end else if (fire) begin
      ptr_r      <= ptr_nxt;
      vec_r      <= vec_nxt;
      mctl_r     <= mctl_nxt;
      imask_r    <= imask_nxt;
      emask_r    <= emask_nxt;
      carrier_r  <= carrier_nxt;
      pend_r     <= pend_nxt;
      estat_r    <= estat_nxt;
      last_irq_r <= last_irq_nxt;
    end
  end

  // The stored line must track the line reported with the last transaction.
  a_last_irq: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> last_irq_r == $past(result.irq_line))
    else $error("last interrupt line does not match reported line");

  // Any control read leaves the pointer at zero.
  a_ptr_clr_rd: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == OP_READ && !item.bus_address[1] |=> ptr_r == 4'd0)
    else $error("pointer not cleared after control read");

  // A point-high command at pointer zero selects the upper register bank.
  a_point_high: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == OP_WRITE && !item.bus_address[1] && ptr_r == 4'd0
      && item.write_data[5:3] == CMD_POINT_HIGH |=> ptr_r[3])
    else $error("point-high command did not set pointer bit 3");

endmodule

// ===== hw/rtl/scc_register_interface_unit.sv =====
// Top level of the serial controller register front end with its handshake stages.
// Each transaction (bus read, bus write or carrier-detect change) passes an input
// register and then a result register, and one transaction is taken in every
// cycle while the result side keeps up. The rate is set by the update of the
// shared register file, which decodes the pointer, updates all channel state and
// forms the interrupt line in one pass. A stalled result holds the input register,
// and the input side stalls only when both stages are full.
module scc_register_interface_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [1:0] in_bus_address,
  input  logic [7:0] in_write_data,
  input  logic       in_dcd_channel,
  input  logic       in_dcd_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq_line,
  output logic       out_irq_changed
);
  import sri_pkg::*;

  logic    in_vld_r;
  item_t   item_r;
  logic    out_vld_r;
  result_t res_r;
  result_t res;
  logic    move;

  assign move     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || move;

  sri_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (move),
    .item   (item_r),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{opcode: in_opcode, bus_address: in_bus_address,
                  write_data: in_write_data, dcd_channel: in_dcd_channel,
                  dcd_level: in_dcd_level};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (move) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_read_data   = res_r.read_data;
  assign out_irq_line    = res_r.irq_line;
  assign out_irq_changed = res_r.irq_changed;

endmodule
